FILE: rtl/swc_pkg.sv
package swc_pkg;

	localparam int TOD_W       = 17;
	localparam int WDAY_W      = 3;
	localparam int LOW_BITS    = 7;
	localparam int DIGIT_W     = 8;
	localparam int REM_W       = 10;
	localparam int VAL_W       = REM_W + DIGIT_W;
	localparam int RECIP_W     = 19;
	localparam int RECIP_SHIFT = 28;
	localparam int LEN_W       = 19;

	// 86400 = 675 * 2^7
	localparam logic [TOD_W-1:0]   DAY_SECONDS = 17'd86400;
	localparam logic [REM_W-1:0]   DIV_ODD     = 10'd675;
	localparam logic [RECIP_W-1:0] DIV_RECIP   = 19'd397683;   // ceil(2^28 / 675)

	localparam logic [WDAY_W-1:0] WEEK_DAYS  = 3'd7;
	localparam logic [WDAY_W-1:0] EPOCH_WDAY = 3'd4;           // day 0 is a Thursday
	localparam logic [WDAY_W-1:0] DAILY_MODE = 3'd0;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_TIME   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DAY  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_DAY    = 2'd3;

	typedef struct packed {
		logic [TOD_W-1:0]  start_time;
		logic [TOD_W-1:0]  end_time;
		logic [WDAY_W-1:0] start_day;
		logic [WDAY_W-1:0] end_day;
	} cfg_t;

	typedef struct packed {
		logic first_in_session;
		logic second_in_session;
		logic same_session;
	} res_t;

	// x mod 7 for x < 512, folding octal digits since 8 = 1 mod 7
	function automatic logic [WDAY_W-1:0] mod7_9(input logic [8:0] x);
		logic [4:0] s;
		logic [3:0] f;
		s = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
		f = 4'(s[4:3]) + 4'(s[2:0]);
		if (f >= 4'(WEEK_DAYS)) begin
			f = f - 4'(WEEK_DAYS);
		end
		return f[WDAY_W-1:0];
	endfunction

	// day mod 7 to weekday, 1 = Sunday
	function automatic logic [WDAY_W-1:0] wday_of(input logic [WDAY_W-1:0] dm);
		logic [3:0] s;
		s = 4'(dm) + 4'(EPOCH_WDAY);
		if (s >= 4'(WEEK_DAYS)) begin
			s = s - 4'(WEEK_DAYS);
		end
		return s[WDAY_W-1:0] + 3'd1;
	endfunction

endpackage

FILE: rtl/swc_if.sv
interface swc_in_if #(parameter int STAMP_BITS = 36);
	logic                  valid;
	logic                  ready;
	logic [STAMP_BITS-1:0] first_time;
	logic [STAMP_BITS-1:0] second_time;

	modport source(output valid, output first_time, output second_time, input ready);
	modport sink(input valid, input first_time, input second_time, output ready);
endinterface

interface swc_out_if;
	logic valid;
	logic ready;
	logic first_in_session;
	logic second_in_session;
	logic same_session;

	modport source(output valid, output first_in_session, output second_in_session,
		output same_session, input ready);
	modport sink(input valid, input first_in_session, input second_in_session,
		input same_session, output ready);
endinterface

FILE: rtl/swc_daysplit.sv
module swc_daysplit #(
	parameter int STAMP_BITS = 36,
	localparam int NDIG = (STAMP_BITS - swc_pkg::LOW_BITS + swc_pkg::DIGIT_W - 1)
		/ swc_pkg::DIGIT_W,
	localparam int DAY_BITS = NDIG * swc_pkg::DIGIT_W
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [STAMP_BITS-1:0]       stamp_in,
	output logic [STAMP_BITS-1:0]       stamp,
	output logic [DAY_BITS-1:0]         day,
	output logic [swc_pkg::TOD_W-1:0]   tod,
	output logic [swc_pkg::WDAY_W-1:0]  wday
);

	localparam int PROD_W = swc_pkg::VAL_W + swc_pkg::RECIP_W;

	logic [STAMP_BITS-1:0]          stamp_s [0:NDIG];
	logic [swc_pkg::REM_W-1:0]      rem_s   [1:NDIG];
	logic [DAY_BITS-1:0]            quo_s   [1:NDIG];
	logic [swc_pkg::WDAY_W-1:0]     dmod_s  [1:NDIG];

	logic [swc_pkg::REM_W-1:0]      nxt_rem  [0:NDIG-1];
	logic [DAY_BITS-1:0]            nxt_quo  [0:NDIG-1];
	logic [swc_pkg::WDAY_W-1:0]     nxt_dmod [0:NDIG-1];

	// long division of stamp >> 7 by 675, one byte per stage, MSB first
	for (genvar i = 0; i < NDIG; i++) begin : g_digit
		logic [DAY_BITS-1:0]          upad;
		logic [swc_pkg::REM_W-1:0]    rem_in;
		logic [DAY_BITS-1:0]          quo_in;
		logic [swc_pkg::WDAY_W-1:0]   dm_in;
		logic [swc_pkg::VAL_W-1:0]    val;
		logic [PROD_W-1:0]            prod;
		logic [swc_pkg::DIGIT_W-1:0]  qd;
		logic [swc_pkg::VAL_W-1:0]    back;

		assign upad = DAY_BITS'(stamp_s[i] >> swc_pkg::LOW_BITS);

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign dm_in  = '0;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign quo_in = quo_s[i];
			assign dm_in  = dmod_s[i];
		end

		assign val  = {rem_in, upad[(NDIG-1-i)*swc_pkg::DIGIT_W +: swc_pkg::DIGIT_W]};
		assign prod = PROD_W'(val) * PROD_W'(swc_pkg::DIV_RECIP);
		assign qd   = prod[swc_pkg::RECIP_SHIFT +: swc_pkg::DIGIT_W];
		assign back = val - swc_pkg::VAL_W'(qd) * swc_pkg::VAL_W'(swc_pkg::DIV_ODD);

		assign nxt_rem[i]  = back[swc_pkg::REM_W-1:0];
		assign nxt_quo[i]  = {quo_in[DAY_BITS-swc_pkg::DIGIT_W-1:0], qd};
		// 256 = 4 mod 7
		assign nxt_dmod[i] = swc_pkg::mod7_9(9'({dm_in, 2'b00}) + 9'(qd));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stamp_s[0] <= stamp_in;
			for (int k = 0; k < NDIG; k++) begin
				stamp_s[k+1] <= stamp_s[k];
				rem_s[k+1]   <= nxt_rem[k];
				quo_s[k+1]   <= nxt_quo[k];
				dmod_s[k+1]  <= nxt_dmod[k];
			end
		end
	end

	assign stamp = stamp_s[NDIG];
	assign day   = quo_s[NDIG];
	assign tod   = {rem_s[NDIG], stamp_s[NDIG][swc_pkg::LOW_BITS-1:0]};
	assign wday  = swc_pkg::wday_of(dmod_s[NDIG]);

endmodule

FILE: rtl/swc_eval.sv
module swc_eval #(
	parameter int STAMP_BITS = 36,
	parameter int DAY_BITS   = 32
) (
	input  swc_pkg::cfg_t                cfg,
	input  logic [STAMP_BITS-1:0]        first_stamp,
	input  logic [STAMP_BITS-1:0]        second_stamp,
	input  logic [DAY_BITS-1:0]          first_day,
	input  logic [DAY_BITS-1:0]          second_day,
	input  logic [swc_pkg::TOD_W-1:0]    first_tod,
	input  logic [swc_pkg::TOD_W-1:0]    second_tod,
	input  logic [swc_pkg::WDAY_W-1:0]   first_wday,
	input  logic [swc_pkg::WDAY_W-1:0]   second_wday,
	output swc_pkg::res_t                res
);

	localparam int KEY_W = DAY_BITS + 2;
	localparam int TW    = swc_pkg::TOD_W;
	localparam int WW    = swc_pkg::WDAY_W;
	localparam int LW    = swc_pkg::LEN_W;

	function automatic logic day_inside(input logic [TW-1:0] t, input logic [TW-1:0] st,
		input logic [TW-1:0] et);
		if (st < et) begin
			return t >= st && t <= et;
		end
		return t >= st || t <= et;
	endfunction

	function automatic logic week_inside(input logic [TW-1:0] t, input logic [WW-1:0] wd,
		input logic [TW-1:0] st, input logic [TW-1:0] et, input logic [WW-1:0] sd,
		input logic [WW-1:0] ed);
		logic outside;
		priority if (sd == ed) begin
			outside = t < st && t > et;
		end else if (sd < ed) begin
			outside = wd < sd || wd > ed || (wd == sd && t < st) || (wd == ed && t > et);
		end else begin
			outside = (wd < sd && wd > ed) || (wd == sd && t < st) || (wd == ed && t > et);
		end
		return !outside;
	endfunction

	// session instance key: day number minus weekday offset to start day
	function automatic logic signed [KEY_W-1:0] week_key(input logic [DAY_BITS-1:0] d,
		input logic [TW-1:0] t, input logic [WW-1:0] wd, input logic [TW-1:0] st,
		input logic [WW-1:0] sd);
		logic signed [3:0] r;
		r = signed'(4'(wd)) - signed'(4'(sd));
		if (r == 4'sd0 && t < st) begin
			r = signed'(4'(swc_pkg::WEEK_DAYS));
		end
		return signed'({2'b00, d}) - KEY_W'(r);
	endfunction

	logic                  daily;
	logic [TW-1:0]         st;
	logic [TW-1:0]         et;
	logic [TW-1:0]         et_eff;
	logic                  in1;
	logic                  in2;
	logic                  stamps_eq;
	logic                  stamps_gt;
	logic [STAMP_BITS-1:0] diff;
	logic signed [LW-1:0]  len;
	logic signed [LW-1:0]  d0;
	logic signed [LW-1:0]  dofs;
	logic signed [LW-1:0]  lim;
	logic signed [LW-1:0]  bound;
	logic                  span_ok;
	logic                  daily_same;
	logic                  weekly_same;

	assign st     = cfg.start_time;
	assign et     = cfg.end_time;
	assign daily  = cfg.start_day == swc_pkg::DAILY_MODE || cfg.end_day == swc_pkg::DAILY_MODE;
	assign et_eff = (cfg.start_day == cfg.end_day && et > st) ? st : et;

	assign in1 = daily ? day_inside(first_tod, st, et)
		: week_inside(first_tod, first_wday, st, et_eff, cfg.start_day, cfg.end_day);
	assign in2 = daily ? day_inside(second_tod, st, et)
		: week_inside(second_tod, second_wday, st, et_eff, cfg.start_day, cfg.end_day);

	assign stamps_eq = first_stamp == second_stamp;
	assign stamps_gt = first_stamp > second_stamp;
	assign diff      = stamps_gt ? first_stamp - second_stamp : second_stamp - first_stamp;

	// overnight session: length and time left in it after the second stamp
	assign len   = LW'(swc_pkg::DAY_SECONDS) - LW'(st) + LW'(et);
	assign d0    = LW'(second_tod) - LW'(st);
	assign dofs  = (d0 < 0) ? d0 + LW'(swc_pkg::DAY_SECONDS) : d0;
	assign lim   = len - dofs;
	assign bound = stamps_gt ? lim : len;
	assign span_ok = bound > 0 && diff < STAMP_BITS'(bound[LW-2:0]);

	assign daily_same  = (st <= et) ? first_day == second_day : span_ok;
	assign weekly_same = week_key(first_day, first_tod, first_wday, st, cfg.start_day)
		== week_key(second_day, second_tod, second_wday, st, cfg.start_day);

	assign res.first_in_session  = in1;
	assign res.second_in_session = in2;
	assign res.same_session      = in1 && in2
		&& (stamps_eq || (daily ? daily_same : weekly_same));

endmodule

FILE: rtl/swc_skid.sv
module swc_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  swc_pkg::res_t    in_res,
	swc_out_if.source        out
);

	logic          out_valid_q;
	logic          skid_valid_q;
	swc_pkg::res_t out_res_q;
	swc_pkg::res_t skid_res_q;
	logic          drain;

	assign drain    = !out_valid_q || out.ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_res_q <= skid_valid_q ? skid_res_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_res_q <= in_res;
		end
	end

	assign out.valid             = out_valid_q;
	assign out.first_in_session  = out_res_q.first_in_session;
	assign out.second_in_session = out_res_q.second_in_session;
	assign out.same_session      = out_res_q.same_session;

endmodule

FILE: rtl/session_window_check.sv
// Session window check. Each transaction carries two UTC epoch-second stamps and
// returns whether each lies inside the configured trading session and whether
// both fall in the same session instance. One transaction is taken every cycle
// while ready is high. The pipeline is an input register, NDIG stages with
// NDIG = ceil((STAMP_BITS - 7) / 8) (NDIG is 4 at the default width), one per
// byte of the divide-by-86400 pipeline that yields day number, time of day and
// weekday, and the output register. The output has a two-entry skid, so ready
// drops only once two results are waiting.
// Configuration writes take effect immediately and belong in idle periods.
module session_window_check #(
	parameter int STAMP_BITS = 36
) (
	input  logic                             clk,
	input  logic                             arst_n,
	swc_in_if.sink                           stamps,
	swc_out_if.source                        verdict,
	input  logic                             cfg_we,
	input  logic [swc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int NDIG = (STAMP_BITS - swc_pkg::LOW_BITS + swc_pkg::DIGIT_W - 1)
		/ swc_pkg::DIGIT_W;
	localparam int DAY_BITS = NDIG * swc_pkg::DIGIT_W;

	swc_pkg::cfg_t cfg_q;
	logic          en;
	logic          vld_s [0:NDIG];

	logic [STAMP_BITS-1:0]          first_stamp;
	logic [STAMP_BITS-1:0]          second_stamp;
	logic [DAY_BITS-1:0]            first_day;
	logic [DAY_BITS-1:0]            second_day;
	logic [swc_pkg::TOD_W-1:0]      first_tod;
	logic [swc_pkg::TOD_W-1:0]      second_tod;
	logic [swc_pkg::WDAY_W-1:0]     first_wday;
	logic [swc_pkg::WDAY_W-1:0]     second_wday;
	swc_pkg::res_t                  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				swc_pkg::CFG_START_TIME: cfg_q.start_time <= cfg_data;
				swc_pkg::CFG_END_TIME:   cfg_q.end_time   <= cfg_data;
				swc_pkg::CFG_START_DAY:  cfg_q.start_day  <= cfg_data[swc_pkg::WDAY_W-1:0];
				swc_pkg::CFG_END_DAY:    cfg_q.end_day    <= cfg_data[swc_pkg::WDAY_W-1:0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	assign stamps.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NDIG; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= stamps.valid;
			for (int k = 0; k < NDIG; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	swc_daysplit #(.STAMP_BITS(STAMP_BITS)) u_split_first (
		.clk      (clk),
		.en       (en),
		.stamp_in (stamps.first_time),
		.stamp    (first_stamp),
		.day      (first_day),
		.tod      (first_tod),
		.wday     (first_wday)
	);

	swc_daysplit #(.STAMP_BITS(STAMP_BITS)) u_split_second (
		.clk      (clk),
		.en       (en),
		.stamp_in (stamps.second_time),
		.stamp    (second_stamp),
		.day      (second_day),
		.tod      (second_tod),
		.wday     (second_wday)
	);

	swc_eval #(.STAMP_BITS(STAMP_BITS), .DAY_BITS(DAY_BITS)) u_eval (
		.cfg          (cfg_q),
		.first_stamp  (first_stamp),
		.second_stamp (second_stamp),
		.first_day    (first_day),
		.second_day   (second_day),
		.first_tod    (first_tod),
		.second_tod   (second_tod),
		.first_wday   (first_wday),
		.second_wday  (second_wday),
		.res          (res)
	);

	swc_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[NDIG]),
		.in_ready (en),
		.in_res   (res),
		.out      (verdict)
	);

endmodule
